[rtl/core/udrb_pkg.sv]
package udrb_pkg;

	localparam int TX_DEPTH = 16;
	localparam int RX_DEPTH = 32;

	// free-running pointers carry one bit more than the store index
	localparam int TX_PTR_W = $clog2(2 * TX_DEPTH);
	localparam int RX_PTR_W = $clog2(2 * RX_DEPTH);
	localparam int TX_IDX_W = $clog2(TX_DEPTH);
	localparam int RX_IDX_W = $clog2(RX_DEPTH);

	// result fill fields have fixed widths
	localparam int TX_FILL_W = 5;
	localparam int RX_FILL_W = 6;

	typedef logic [TX_PTR_W-1:0] tx_ptr_t;
	typedef logic [RX_PTR_W-1:0] rx_ptr_t;
	typedef logic [TX_IDX_W-1:0] tx_idx_t;
	typedef logic [RX_IDX_W-1:0] rx_idx_t;

	localparam tx_ptr_t TX_DEPTH_P = TX_PTR_W'(TX_DEPTH);
	localparam tx_ptr_t TX_SPAN    = TX_PTR_W'(2 * TX_DEPTH);
	localparam tx_ptr_t TX_LAST    = TX_PTR_W'(2 * TX_DEPTH - 1);
	localparam rx_ptr_t RX_DEPTH_P = RX_PTR_W'(RX_DEPTH);
	localparam rx_ptr_t RX_SPAN    = RX_PTR_W'(2 * RX_DEPTH);
	localparam rx_ptr_t RX_LAST    = RX_PTR_W'(2 * RX_DEPTH - 1);

	typedef enum logic [1:0] {
		MODE_PUT     = 2'd0,
		MODE_GET     = 2'd1,
		MODE_RX_BYTE = 2'd2,
		MODE_TX_DONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_TX_FULL     = 2'd1,
		ST_RX_EMPTY    = 2'd2,
		ST_RX_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  data_byte;
	} cmd_t;

	typedef struct packed {
		status_t               status;
		logic [7:0]            read_byte;
		logic                  line_out_valid;
		logic [7:0]            line_out_byte;
		logic [RX_FILL_W-1:0]  rx_fill;
		logic [TX_FILL_W-1:0]  tx_fill;
	} rsp_t;

	function automatic tx_ptr_t tx_ptr_next(tx_ptr_t p);
		return (p == TX_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic rx_ptr_t rx_ptr_next(rx_ptr_t p);
		return (p == RX_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic tx_idx_t tx_slot(tx_ptr_t p);
		tx_ptr_t s;
		s = (p >= TX_DEPTH_P) ? p - TX_DEPTH_P : p;
		return s[TX_IDX_W-1:0];
	endfunction

	function automatic rx_idx_t rx_slot(rx_ptr_t p);
		rx_ptr_t s;
		s = (p >= RX_DEPTH_P) ? p - RX_DEPTH_P : p;
		return s[RX_IDX_W-1:0];
	endfunction

	function automatic tx_ptr_t tx_fill_of(tx_ptr_t w, tx_ptr_t r);
		return (w >= r) ? w - r : w + TX_SPAN - r;
	endfunction

	function automatic rx_ptr_t rx_fill_of(rx_ptr_t w, rx_ptr_t r);
		return (w >= r) ? w - r : w + RX_SPAN - r;
	endfunction

	function automatic logic [TX_FILL_W-1:0] tx_fill_field(tx_ptr_t f);
		return TX_FILL_W'(f);
	endfunction

	function automatic logic [RX_FILL_W-1:0] rx_fill_field(rx_ptr_t f);
		return RX_FILL_W'(f);
	endfunction

endpackage

[rtl/core/udrb_ram.sv]
module udrb_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/uart_dual_ring_buffer_top.sv]
// Dual byte ring buffer between a host and a serial line.
// Command channel: cmd (mode, data_byte) is transferred at a rising edge with
// start high and busy low. busy never rises, so a command may be issued in
// every cycle.
// Modes: host put into the transmit ring, host get from the receive ring,
// line byte received into the receive ring, line transmit done.
// Result channel: result is valid for exactly one cycle with done high, in the
// cycle after the command transfer. The receiver cannot stall it; each result
// is taken in its cycle.
// Throughput one command per cycle. The result timing is set by the registered
// read port of each ring store: the head byte of the
// transmit ring or the receive ring comes out of the store in the result cycle.
// A put into an empty ring that restarts an idle transmitter forwards the new
// byte instead of reading the store.
// Reset: pointers cleared, both rings empty, transmitter idle, no result
// pending. The stores need no clearing; only written entries are ever read.
module uart_dual_ring_buffer_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  udrb_pkg::cmd_t  cmd,
	output logic            done,
	output udrb_pkg::rsp_t  result
);

	udrb_pkg::tx_ptr_t tx_wp_q, tx_rp_q;
	udrb_pkg::rx_ptr_t rx_wp_q, rx_rp_q;
	logic              tx_idle_q;

	udrb_pkg::tx_ptr_t tx_fill, tx_fill_nx;
	udrb_pkg::rx_ptr_t rx_fill, rx_fill_nx;
	logic              accept;
	logic              put_ok, pump, send, fwd, get_ok, rx_wr;
	logic [7:0]        tx_rdata, rx_rdata;

	// result stage
	logic                       valid_s1;
	udrb_pkg::status_t          status_s1;
	logic                       send_s1, fwd_s1, get_s1;
	logic [7:0]                 fwd_data_s1;
	logic [udrb_pkg::TX_FILL_W-1:0] tx_fill_s1;
	logic [udrb_pkg::RX_FILL_W-1:0] rx_fill_s1;

	// no step ever stalls, nothing to hold off
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign tx_fill = udrb_pkg::tx_fill_of(tx_wp_q, tx_rp_q);
	assign rx_fill = udrb_pkg::rx_fill_of(rx_wp_q, rx_rp_q);

	always_comb begin
		put_ok = accept && (cmd.mode == udrb_pkg::MODE_PUT) &&
			(tx_fill < udrb_pkg::TX_DEPTH_P);
		// restart on a put to an idle transmitter, or the next byte on tx done
		pump   = (put_ok && tx_idle_q) ||
			(accept && (cmd.mode == udrb_pkg::MODE_TX_DONE));
		// after a put the ring holds at least the new byte
		send   = pump && (put_ok || (tx_fill != '0));
		// head slot equals the slot being written when the ring was empty
		fwd    = put_ok && (tx_fill == '0);
		get_ok = accept && (cmd.mode == udrb_pkg::MODE_GET) && (rx_fill != '0);
		rx_wr  = accept && (cmd.mode == udrb_pkg::MODE_RX_BYTE) &&
			(rx_fill < udrb_pkg::RX_DEPTH_P);
		tx_fill_nx = tx_fill + udrb_pkg::tx_ptr_t'(put_ok) - udrb_pkg::tx_ptr_t'(send);
		rx_fill_nx = rx_fill + udrb_pkg::rx_ptr_t'(rx_wr) - udrb_pkg::rx_ptr_t'(get_ok);
	end

	udrb_ram #(
		.DEPTH (udrb_pkg::TX_DEPTH),
		.WIDTH (8)
	) u_tx_store (
		.clk   (clk),
		.we    (put_ok),
		.waddr (udrb_pkg::tx_slot(tx_wp_q)),
		.wdata (cmd.data_byte),
		.re    (send && !fwd),
		.raddr (udrb_pkg::tx_slot(tx_rp_q)),
		.rdata (tx_rdata)
	);

	udrb_ram #(
		.DEPTH (udrb_pkg::RX_DEPTH),
		.WIDTH (8)
	) u_rx_store (
		.clk   (clk),
		.we    (rx_wr),
		.waddr (udrb_pkg::rx_slot(rx_wp_q)),
		.wdata (cmd.data_byte),
		.re    (get_ok),
		.raddr (udrb_pkg::rx_slot(rx_rp_q)),
		.rdata (rx_rdata)
	);

	// pointers, transmitter state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wp_q   <= '0;
			tx_rp_q   <= '0;
			rx_wp_q   <= '0;
			rx_rp_q   <= '0;
			tx_idle_q <= 1'b1;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (put_ok) begin
				tx_wp_q <= udrb_pkg::tx_ptr_next(tx_wp_q);
			end
			if (send) begin
				tx_rp_q <= udrb_pkg::tx_ptr_next(tx_rp_q);
			end
			if (pump) begin
				tx_idle_q <= ~send;
			end
			if (rx_wr) begin
				rx_wp_q <= udrb_pkg::rx_ptr_next(rx_wp_q);
			end
			if (get_ok) begin
				rx_rp_q <= udrb_pkg::rx_ptr_next(rx_rp_q);
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			send_s1     <= send;
			fwd_s1      <= fwd;
			get_s1      <= get_ok;
			fwd_data_s1 <= cmd.data_byte;
			tx_fill_s1  <= udrb_pkg::tx_fill_field(tx_fill_nx);
			rx_fill_s1  <= udrb_pkg::rx_fill_field(rx_fill_nx);
			unique case (cmd.mode)
				udrb_pkg::MODE_PUT: begin
					status_s1 <= put_ok ? udrb_pkg::ST_OK : udrb_pkg::ST_TX_FULL;
				end
				udrb_pkg::MODE_GET: begin
					status_s1 <= get_ok ? udrb_pkg::ST_OK : udrb_pkg::ST_RX_EMPTY;
				end
				udrb_pkg::MODE_RX_BYTE: begin
					status_s1 <= rx_wr ? udrb_pkg::ST_OK : udrb_pkg::ST_RX_OVERFLOW;
				end
				default: begin
					status_s1 <= udrb_pkg::ST_OK;
				end
			endcase
		end
	end

	assign done = valid_s1;

	always_comb begin
		result.status         = status_s1;
		result.read_byte      = get_s1 ? rx_rdata : 8'h00;
		result.line_out_valid = send_s1;
		result.line_out_byte  = send_s1 ? (fwd_s1 ? fwd_data_s1 : tx_rdata) : 8'h00;
		result.rx_fill        = rx_fill_s1;
		result.tx_fill        = tx_fill_s1;
	end

	// an idle transmitter always sits on an empty ring
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		tx_idle_q |-> (tx_fill == '0))
		else $error("transmitter idle with bytes queued");

	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill <= udrb_pkg::TX_DEPTH_P)
		else $error("transmit fill above depth");

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill <= udrb_pkg::RX_DEPTH_P)
		else $error("receive fill above depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result missing after command transfer");

	a_send_moves_rp: assert property (@(posedge clk) disable iff (!arst_n)
		send |=> (tx_rp_q != $past(tx_rp_q)))
		else $error("byte sent without read pointer advance");

endmodule

[test/tb_uart_dual_ring_buffer_top.sv]
module tb_uart_dual_ring_buffer_top;
	timeunit 1ns;
	timeprecision 1ps;

	// directed row: mode, first data byte, repeat count (data steps by one per repeat),
	// and a typed-in result where it is plain from the ring state
	typedef struct {
		udrb_pkg::mode_t mode;
		logic [7:0]      data;
		int              reps;
		bit              chk;
		udrb_pkg::rsp_t  val;
	} row_t;

	// per-transfer note from the driver: use the typed-in result or the predictor's
	typedef struct {
		bit             chk;
		udrb_pkg::rsp_t val;
	} known_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	udrb_pkg::cmd_t cmd;
	logic           done;
	udrb_pkg::rsp_t result;

	int             errors = 0;
	udrb_pkg::rsp_t expected_q[$];
	known_t         typed_q[$];
	row_t           plan[$];
	known_t         typed;
	udrb_pkg::rsp_t model_out;

	udrb_pkg::mode_t all_modes[4] = '{udrb_pkg::MODE_PUT, udrb_pkg::MODE_GET,
		udrb_pkg::MODE_RX_BYTE, udrb_pkg::MODE_TX_DONE};

	// predictor state: both ring stores, free-running pointers, transmitter idle flag
	logic [7:0]        tx_mem [udrb_pkg::TX_DEPTH];
	logic [7:0]        rx_mem [udrb_pkg::RX_DEPTH];
	udrb_pkg::tx_ptr_t tx_wr  = '0;
	udrb_pkg::tx_ptr_t tx_rd  = '0;
	udrb_pkg::rx_ptr_t rx_wr  = '0;
	udrb_pkg::rx_ptr_t rx_rd  = '0;
	logic              tx_off = 1'b1;

	uart_dual_ring_buffer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: far beyond the slowest legal run (every item followed by the longest idle gap)
	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// bytes held: pointers run modulo twice the depth
	function automatic int ring_level(int wr, int rd, int depth);
		return (wr >= rd) ? wr - rd : wr + 2 * depth - rd;
	endfunction

	function automatic int ring_bump(int p, int depth);
		return (p + 1 >= 2 * depth) ? 0 : p + 1;
	endfunction

	function automatic int ring_index(int p, int depth);
		return (p >= depth) ? p - depth : p;
	endfunction

	// hand the head byte to the line, or park the transmitter when nothing is queued
	function automatic void tx_launch(inout udrb_pkg::rsp_t r);
		if (ring_level(tx_wr, tx_rd, udrb_pkg::TX_DEPTH) != 0) begin
			r.line_out_valid = 1'b1;
			r.line_out_byte  = tx_mem[ring_index(tx_rd, udrb_pkg::TX_DEPTH)];
			tx_rd            = udrb_pkg::tx_ptr_t'(ring_bump(tx_rd, udrb_pkg::TX_DEPTH));
			tx_off           = 1'b0;
		end else begin
			tx_off = 1'b1;
		end
	endfunction

	function automatic udrb_pkg::rsp_t predict_step(udrb_pkg::cmd_t c);
		udrb_pkg::rsp_t r;
		int             rx_lvl;
		int             tx_lvl;
		r = '0;
		r.status = udrb_pkg::ST_OK;
		case (c.mode)
			udrb_pkg::MODE_PUT: begin
				if (ring_level(tx_wr, tx_rd, udrb_pkg::TX_DEPTH) >= udrb_pkg::TX_DEPTH) begin
					r.status = udrb_pkg::ST_TX_FULL;
				end else begin
					tx_mem[ring_index(tx_wr, udrb_pkg::TX_DEPTH)] = c.data_byte;
					tx_wr = udrb_pkg::tx_ptr_t'(ring_bump(tx_wr, udrb_pkg::TX_DEPTH));
					// an idle transmitter restarts and ships the head byte at once
					if (tx_off)
						tx_launch(r);
				end
			end
			udrb_pkg::MODE_GET: begin
				if (ring_level(rx_wr, rx_rd, udrb_pkg::RX_DEPTH) == 0) begin
					r.status = udrb_pkg::ST_RX_EMPTY;
				end else begin
					r.read_byte = rx_mem[ring_index(rx_rd, udrb_pkg::RX_DEPTH)];
					rx_rd = udrb_pkg::rx_ptr_t'(ring_bump(rx_rd, udrb_pkg::RX_DEPTH));
				end
			end
			udrb_pkg::MODE_RX_BYTE: begin
				if (ring_level(rx_wr, rx_rd, udrb_pkg::RX_DEPTH) >= udrb_pkg::RX_DEPTH) begin
					r.status = udrb_pkg::ST_RX_OVERFLOW;
				end else begin
					rx_mem[ring_index(rx_wr, udrb_pkg::RX_DEPTH)] = c.data_byte;
					rx_wr = udrb_pkg::rx_ptr_t'(ring_bump(rx_wr, udrb_pkg::RX_DEPTH));
				end
			end
			default: begin
				tx_launch(r);
			end
		endcase
		// fill fields keep only their low bits
		rx_lvl    = ring_level(rx_wr, rx_rd, udrb_pkg::RX_DEPTH);
		tx_lvl    = ring_level(tx_wr, tx_rd, udrb_pkg::TX_DEPTH);
		r.rx_fill = rx_lvl[udrb_pkg::RX_FILL_W-1:0];
		r.tx_fill = tx_lvl[udrb_pkg::TX_FILL_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string msg);
		errors++;
		$display("%0d ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_result(udrb_pkg::rsp_t got, udrb_pkg::rsp_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.read_byte !== want.read_byte)
			report_mismatch($sformatf("read_byte got %h want %h", got.read_byte,
				want.read_byte));
		if (got.line_out_valid !== want.line_out_valid)
			report_mismatch($sformatf("line_out_valid got %b want %b", got.line_out_valid,
				want.line_out_valid));
		if (got.line_out_byte !== want.line_out_byte)
			report_mismatch($sformatf("line_out_byte got %h want %h", got.line_out_byte,
				want.line_out_byte));
		if (got.rx_fill !== want.rx_fill)
			report_mismatch($sformatf("rx_fill got %0d want %0d", got.rx_fill, want.rx_fill));
		if (got.tx_fill !== want.tx_fill)
			report_mismatch($sformatf("tx_fill got %0d want %0d", got.tx_fill, want.tx_fill));
	endtask

	// Everything here samples pre-edge values, so the order against the DUT's own
	// flops at the same edge does not matter. A result strobe is checked before
	// this edge's command transfer is queued; the result of a transfer shows up
	// in the next cycle, so the queue stays in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0)
					report_mismatch($sformatf("result %h with nothing pending", result));
				else
					check_result(result, expected_q.pop_front());
			end
			if (start && !busy) begin
				typed = typed_q.pop_front();
				// the predictor always runs so its ring state tracks the DUT
				model_out = predict_step(cmd);
				expected_q.push_back(typed.chk ? typed.val : model_out);
			end
		end
	end

	// ---------------------------------------------------------------- driving

	function automatic row_t plain(udrb_pkg::mode_t m, logic [7:0] d, int n);
		row_t r;
		r.mode = m;
		r.data = d;
		r.reps = n;
		r.chk  = 1'b0;
		r.val  = '0;
		return r;
	endfunction

	function automatic row_t known(udrb_pkg::mode_t m, logic [7:0] d,
			udrb_pkg::status_t st, logic [7:0] rd, logic lv, logic [7:0] lb,
			int rxf, int txf);
		row_t r;
		r = plain(m, d, 1);
		r.chk                = 1'b1;
		r.val.status         = st;
		r.val.read_byte      = rd;
		r.val.line_out_valid = lv;
		r.val.line_out_byte  = lb;
		r.val.rx_fill        = rxf[udrb_pkg::RX_FILL_W-1:0];
		r.val.tx_fill        = txf[udrb_pkg::TX_FILL_W-1:0];
		return r;
	endfunction

	// Present one command and hold it until transferred. start is left high so a
	// back-to-back command only changes cmd; a gap lowers it in pause_sender.
	task automatic issue(udrb_pkg::mode_t m, logic [7:0] d, bit chk, udrb_pkg::rsp_t val);
		known_t         k;
		udrb_pkg::cmd_t c;
		k.chk = chk;
		k.val = val;
		typed_q.push_back(k);
		c.mode      = m;
		c.data_byte = d;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle(int pct);
		if ($urandom_range(0, 99) < pct)
			pause_sender($urandom_range(1, 11));
	endtask

	// hold off until every queued result has come back; checked on the falling
	// edge so the monitor's work at the rising edge has settled
	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (expected_q.size() != 0);
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- stimulus

	initial begin
		int              i;
		int              n;
		int              seg_left;
		int              bias;
		int              idle_pct;
		udrb_pkg::mode_t m;

		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;

		// after reset: both rings empty, transmitter idle
		plan.push_back(known(udrb_pkg::MODE_GET,     8'h00, udrb_pkg::ST_RX_EMPTY,
			8'h00, 1'b0, 8'h00, 0, 0));
		plan.push_back(known(udrb_pkg::MODE_TX_DONE, 8'hFF, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 0, 0));
		// put restarts the idle transmitter: byte goes straight to the line
		plan.push_back(known(udrb_pkg::MODE_PUT,     8'hFF, udrb_pkg::ST_OK,
			8'h00, 1'b1, 8'hFF, 0, 0));
		// transmitter now busy: byte is only queued
		plan.push_back(known(udrb_pkg::MODE_PUT,     8'h00, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 0, 1));
		plan.push_back(known(udrb_pkg::MODE_TX_DONE, 8'h5A, udrb_pkg::ST_OK,
			8'h00, 1'b1, 8'h00, 0, 0));
		// transmit done on an empty ring parks the transmitter
		plan.push_back(known(udrb_pkg::MODE_TX_DONE, 8'hA5, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 0, 0));
		plan.push_back(known(udrb_pkg::MODE_RX_BYTE, 8'hFF, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 1, 0));
		plan.push_back(known(udrb_pkg::MODE_RX_BYTE, 8'h00, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 2, 0));
		plan.push_back(known(udrb_pkg::MODE_GET,     8'hAA, udrb_pkg::ST_OK,
			8'hFF, 1'b0, 8'h00, 1, 0));
		plan.push_back(known(udrb_pkg::MODE_GET,     8'h55, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 0, 0));
		plan.push_back(known(udrb_pkg::MODE_GET,     8'hFF, udrb_pkg::ST_RX_EMPTY,
			8'h00, 1'b0, 8'h00, 0, 0));
		// fill the transmit ring behind a busy transmitter, then overrun it
		plan.push_back(known(udrb_pkg::MODE_PUT,     8'h80, udrb_pkg::ST_OK,
			8'h00, 1'b1, 8'h80, 0, 0));
		plan.push_back(plain(udrb_pkg::MODE_PUT,     8'h01, udrb_pkg::TX_DEPTH));
		plan.push_back(known(udrb_pkg::MODE_PUT,     8'h55, udrb_pkg::ST_TX_FULL,
			8'h00, 1'b0, 8'h00, 0, 16));
		plan.push_back(known(udrb_pkg::MODE_TX_DONE, 8'h00, udrb_pkg::ST_OK,
			8'h00, 1'b1, 8'h01, 0, 15));
		plan.push_back(known(udrb_pkg::MODE_PUT,     8'hC3, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 0, 16));
		plan.push_back(plain(udrb_pkg::MODE_TX_DONE, 8'h00, udrb_pkg::TX_DEPTH));
		plan.push_back(known(udrb_pkg::MODE_TX_DONE, 8'hFF, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 0, 0));
		// fill the receive ring past the end of its store, overflow it, refill the freed slot, then drain it
		plan.push_back(plain(udrb_pkg::MODE_RX_BYTE, 8'h10, udrb_pkg::RX_DEPTH));
		plan.push_back(known(udrb_pkg::MODE_RX_BYTE, 8'hEE, udrb_pkg::ST_RX_OVERFLOW,
			8'h00, 1'b0, 8'h00, 32, 0));
		plan.push_back(known(udrb_pkg::MODE_GET,     8'h00, udrb_pkg::ST_OK,
			8'h10, 1'b0, 8'h00, 31, 0));
		plan.push_back(known(udrb_pkg::MODE_RX_BYTE, 8'h7F, udrb_pkg::ST_OK,
			8'h00, 1'b0, 8'h00, 32, 0));
		plan.push_back(plain(udrb_pkg::MODE_GET,     8'h00, udrb_pkg::RX_DEPTH));
		plan.push_back(known(udrb_pkg::MODE_GET,     8'h00, udrb_pkg::ST_RX_EMPTY,
			8'h00, 1'b0, 8'h00, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			for (i = 0; i < plan[k].reps; i++) begin
				issue(plan[k].mode, 8'(plan[k].data + i), plan[k].chk, plan[k].val);
				maybe_idle(20);
			end
		end
		drain_results();

		// Random part in segments, each leaning on one mode or on none, so the rings
		// drift to full or to empty and wrap many times; some segments run with no gaps.
		seg_left = 0;
		bias     = 0;
		idle_pct = 0;
		for (n = 0; n < 634; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 60);
				bias     = $urandom_range(0, 4);
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
			end
			seg_left--;
			if (bias < 4 && $urandom_range(0, 99) < 55)
				m = all_modes[bias];
			else
				m = all_modes[$urandom_range(0, 3)];
			issue(m, 8'($urandom_range(0, 255)), 1'b0, '0);
			if (n == 320)
				drain_results();
			else if (n < 520)
				maybe_idle(idle_pct);
		end

		drain_results();
		repeat (4) @(posedge clk);

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[uart_dual_ring_buffer_top.f]
rtl/core/udrb_pkg.sv
rtl/core/udrb_ram.sv
rtl/core/uart_dual_ring_buffer_top.sv
test/tb_uart_dual_ring_buffer_top.sv
